// File: rtl/core/mstk_pkg.sv
// Shared types and constants for the maximum spanning tree unit.
package mstk_pkg;

   localparam int VERTEX_BITS = 6;
   localparam int VCOUNT_BITS = 7;
   localparam int RANK_BITS   = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 7'd64;
   localparam logic [RANK_BITS-1:0]   RANK_ONE     = 3'd1;

   typedef enum logic [1:0] {
      F_LOAD,
      F_SCAN,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_RDA,
      B_CHA,
      B_RDB,
      B_CHB,
      B_UN1,
      B_UN2,
      B_SEND,
      B_FIN
   } back_state_type;

endpackage

// File: rtl/core/mstk_ram.sv
// Generic simple dual-port RAM with registered read data.
module mstk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/mstk_fifo.sv
// Short queue carrying ordered edges from the front part to the back part.
module mstk_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != (PW+1)'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/mstk_front.sv
// Front part: loads edges and hands them out in descending weight order.
module mstk_front import mstk_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [VERTEX_BITS-1:0]               in_from,
   input  logic [VERTEX_BITS-1:0]               in_to,
   input  logic [WEIGHT_BITS-1:0]               in_weight,
   input  logic                                 req_tlast,
   input  logic [VCOUNT_BITS-1:0]               vertex_count,
   output logic                                 q_valid,
   input  logic                                 q_ready,
   output logic [2*VERTEX_BITS+WEIGHT_BITS:0]   q_data
);

   localparam int EW    = 2 * VERTEX_BITS + WEIGHT_BITS;
   localparam int IDX_W = $clog2(MAX_EDGES);
   localparam int CNT_W = $clog2(MAX_EDGES + 1);

   front_state_type state_ff, state_in;

   logic [CNT_W-1:0]              total_ff, total_in;
   logic [CNT_W-1:0]              addr_ff, addr_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]              rd_idx_ff, rd_idx_in;
   logic                          best_valid_ff, best_valid_in;
   logic signed [WEIGHT_BITS-1:0] best_w_ff, best_w_in;
   logic [IDX_W-1:0]              best_idx_ff, best_idx_in;
   logic [VERTEX_BITS-1:0]        best_from_ff, best_from_in;
   logic [VERTEX_BITS-1:0]        best_to_ff, best_to_in;
   logic                          has_prev_ff, has_prev_in;
   logic signed [WEIGHT_BITS-1:0] prev_w_ff, prev_w_in;
   logic [IDX_W-1:0]              prev_idx_ff, prev_idx_in;

   logic [VCOUNT_BITS-1:0]        nv;
   logic                          accept, wr_en, issue, pass_done;
   logic [EW-1:0]                 rd_data;
   logic [VERTEX_BITS-1:0]        c_from, c_to;
   logic signed [WEIGHT_BITS-1:0] c_w;
   logic                          in_range, after_prev, better;

   assign nv = (vertex_count > VCOUNT_BITS'(MAX_VERTICES)) ?
               VCOUNT_BITS'(MAX_VERTICES) : vertex_count;

   assign req_tready = state_ff == F_LOAD;
   assign accept     = req_tvalid && req_tready;
   assign wr_en      = accept && (total_ff < CNT_W'(MAX_EDGES));
   assign issue      = (state_ff == F_SCAN) && (addr_ff < total_ff);
   assign pass_done  = (state_ff == F_SCAN) && !issue && !rd_valid_ff;

   mstk_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (total_ff[IDX_W-1:0]),
      .wr_data ({in_weight, in_to, in_from}),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign c_from = rd_data[VERTEX_BITS-1:0];
   assign c_to   = rd_data[2*VERTEX_BITS-1:VERTEX_BITS];
   assign c_w    = $signed(rd_data[EW-1:2*VERTEX_BITS]);

   // Order key is weight descending, then load index ascending.
   assign in_range   = ({1'b0, c_from} < nv) && ({1'b0, c_to} < nv);
   assign after_prev = !has_prev_ff || (c_w < prev_w_ff) ||
                       ((c_w == prev_w_ff) && (rd_idx_ff > prev_idx_ff));
   assign better     = !best_valid_ff || (c_w > best_w_ff);

   assign q_valid = state_ff == F_PUSH;
   assign q_data  = {!best_valid_ff, best_w_ff, best_to_ff, best_from_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_LOAD: begin
            if (accept && req_tlast) begin
               state_in = F_SCAN;
            end
         end
         F_SCAN: begin
            if (pass_done) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (q_ready) begin
               state_in = best_valid_ff ? F_SCAN : F_LOAD;
            end
         end
         default: begin
            state_in = F_LOAD;
         end
      endcase
   end

   always_comb begin
      total_in      = total_ff;
      addr_in       = addr_ff;
      rd_valid_in   = issue;
      rd_idx_in     = addr_ff[IDX_W-1:0];
      best_valid_in = best_valid_ff;
      best_w_in     = best_w_ff;
      best_idx_in   = best_idx_ff;
      best_from_in  = best_from_ff;
      best_to_in    = best_to_ff;
      has_prev_in   = has_prev_ff;
      prev_w_in     = prev_w_ff;
      prev_idx_in   = prev_idx_ff;
      if (wr_en) begin
         total_in = total_ff + 1'b1;
      end
      if (issue) begin
         addr_in = addr_ff + 1'b1;
      end
      if (rd_valid_ff && in_range && after_prev && better) begin
         best_valid_in = 1'b1;
         best_w_in     = c_w;
         best_idx_in   = rd_idx_ff;
         best_from_in  = c_from;
         best_to_in    = c_to;
      end
      if (state_ff == F_PUSH && q_ready) begin
         addr_in       = '0;
         best_valid_in = 1'b0;
         if (best_valid_ff) begin
            has_prev_in = 1'b1;
            prev_w_in   = best_w_ff;
            prev_idx_in = best_idx_ff;
         end else begin
            has_prev_in = 1'b0;
            total_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_LOAD;
         total_ff      <= '0;
         addr_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         has_prev_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         addr_ff       <= addr_in;
         rd_valid_ff   <= rd_valid_in;
         best_valid_ff <= best_valid_in;
         has_prev_ff   <= has_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      best_w_ff    <= best_w_in;
      best_idx_ff  <= best_idx_in;
      best_from_ff <= best_from_in;
      best_to_ff   <= best_to_in;
      prev_w_ff    <= prev_w_in;
      prev_idx_ff  <= prev_idx_in;
   end

endmodule

// File: rtl/core/mstk_back.sv
// Back part: union-find over ordered edges and output of the tree edges.
module mstk_back import mstk_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   output logic                               q_ready,
   input  logic [2*VERTEX_BITS+WEIGHT_BITS:0] q_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [VERTEX_BITS-1:0]             out_from,
   output logic [VERTEX_BITS-1:0]             out_to,
   output logic [WEIGHT_BITS-1:0]             out_weight,
   output logic                               out_ok,
   output logic                               out_last
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int PW = VW + RANK_BITS;

   back_state_type state_ff, state_in;

   logic [VERTEX_BITS-1:0]  e_from_ff, e_to_ff;
   logic [WEIGHT_BITS-1:0]  e_w_ff;
   logic [VW-1:0]           cur_ff, cur_in;
   logic [VW-1:0]           root_a_ff, root_a_in, root_b_ff, root_b_in;
   logic [RANK_BITS-1:0]    rank_a_ff, rank_a_in, rank_b_ff, rank_b_in;
   logic [MAX_VERTICES-1:0] valid_ff;
   logic                    pend_valid_ff;
   logic [VERTEX_BITS-1:0]  pend_from_ff, pend_to_ff;
   logic [WEIGHT_BITS-1:0]  pend_w_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_BITS-1:0]  rsp_from_ff, rsp_to_ff;
   logic [WEIGHT_BITS-1:0]  rsp_w_ff;
   logic                    rsp_ok_ff, rsp_last_ff;

   logic                    pop, q_end, slot_free, is_root;
   logic [PW-1:0]           rd_data, wr_data;
   logic [VW-1:0]           wr_addr, eff_parent;
   logic [RANK_BITS-1:0]    eff_rank;
   logic                    wr_en;

   assign q_ready   = state_ff == B_IDLE;
   assign pop       = q_valid && q_ready;
   assign q_end     = q_data[2*VERTEX_BITS+WEIGHT_BITS];
   assign slot_free = !rsp_valid_ff || rsp_tready;

   mstk_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_parent_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cur_ff),
      .rd_data (rd_data)
   );

   // An entry not written since the run began is its own root with rank one.
   assign eff_parent = valid_ff[cur_ff] ? rd_data[VW-1:0] : cur_ff;
   assign eff_rank   = valid_ff[cur_ff] ? rd_data[PW-1:VW] : RANK_ONE;
   assign is_root    = eff_parent == cur_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop) begin
               state_in = q_end ? B_FIN : B_RDA;
            end
         end
         B_RDA: state_in = B_CHA;
         B_CHA: state_in = is_root ? B_RDB : B_RDA;
         B_RDB: state_in = B_CHB;
         B_CHB: begin
            if (!is_root) begin
               state_in = B_RDB;
            end else if (cur_ff == root_a_ff) begin
               state_in = B_IDLE;
            end else begin
               state_in = B_UN1;
            end
         end
         B_UN1: state_in = (rank_a_ff == rank_b_ff) ? B_UN2 : B_SEND;
         B_UN2: state_in = B_SEND;
         B_SEND: begin
            if (!pend_valid_ff || slot_free) begin
               state_in = B_IDLE;
            end
         end
         B_FIN: begin
            if (slot_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      cur_in    = cur_ff;
      root_a_in = root_a_ff;
      rank_a_in = rank_a_ff;
      root_b_in = root_b_ff;
      rank_b_in = rank_b_ff;
      wr_en     = 1'b0;
      wr_addr   = root_b_ff;
      wr_data   = {rank_b_ff, root_a_ff};
      case (state_ff)
         B_IDLE: begin
            cur_in = q_data[VW-1:0];
         end
         B_CHA: begin
            if (is_root) begin
               root_a_in = cur_ff;
               rank_a_in = eff_rank;
               cur_in    = e_to_ff[VW-1:0];
            end else begin
               cur_in = eff_parent;
            end
         end
         B_CHB: begin
            if (is_root) begin
               root_b_in = cur_ff;
               rank_b_in = eff_rank;
            end else begin
               cur_in = eff_parent;
            end
         end
         B_UN1: begin
            wr_en = 1'b1;
            if (rank_a_ff < rank_b_ff) begin
               wr_addr = root_a_ff;
               wr_data = {rank_a_ff, root_b_ff};
            end
         end
         B_UN2: begin
            wr_en   = 1'b1;
            wr_addr = root_a_ff;
            wr_data = {rank_a_ff + 1'b1, root_a_ff};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (state_ff == B_SEND && pend_valid_ff && slot_free) begin
         rsp_valid_in = 1'b1;
      end
      if (state_ff == B_FIN && slot_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (state_ff == B_SEND && !pend_valid_ff) begin
            pend_valid_ff <= 1'b1;
         end
         if (state_ff == B_FIN && slot_free) begin
            pend_valid_ff <= 1'b0;
            valid_ff      <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      root_a_ff <= root_a_in;
      rank_a_ff <= rank_a_in;
      root_b_ff <= root_b_in;
      rank_b_ff <= rank_b_in;
      if (pop) begin
         e_from_ff <= q_data[VERTEX_BITS-1:0];
         e_to_ff   <= q_data[2*VERTEX_BITS-1:VERTEX_BITS];
         e_w_ff    <= q_data[2*VERTEX_BITS+WEIGHT_BITS-1:2*VERTEX_BITS];
      end
      if (state_ff == B_SEND && (!pend_valid_ff || slot_free)) begin
         pend_from_ff <= e_from_ff;
         pend_to_ff   <= e_to_ff;
         pend_w_ff    <= e_w_ff;
      end
      // A held edge goes out only once it is known whether another follows.
      if (state_ff == B_SEND && pend_valid_ff && slot_free) begin
         rsp_from_ff <= pend_from_ff;
         rsp_to_ff   <= pend_to_ff;
         rsp_w_ff    <= pend_w_ff;
         rsp_ok_ff   <= 1'b1;
         rsp_last_ff <= 1'b0;
      end
      if (state_ff == B_FIN && slot_free) begin
         rsp_from_ff <= pend_valid_ff ? pend_from_ff : '0;
         rsp_to_ff   <= pend_valid_ff ? pend_to_ff : '0;
         rsp_w_ff    <= pend_valid_ff ? pend_w_ff : '0;
         rsp_ok_ff   <= pend_valid_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign out_from   = rsp_from_ff;
   assign out_to     = rsp_to_ff;
   assign out_weight = rsp_w_ff;
   assign out_ok     = rsp_ok_ff;
   assign out_last   = rsp_last_ff;

endmodule

// File: rtl/core/max_spanning_tree_kruskal_unit.sv
// Top level of the maximum spanning tree unit (Kruskal with union-find).
// Edges load at one per cycle while the front part is in its load state; the edge marked last starts the run.
// The ordering scan makes one pass over the edge RAM per in-range edge plus one.
// Union-find walks step through each tree level with a read state and a check state, and overlap the scan.
// Reset is synchronous; it empties the edge store and sets vertex_count to 64.
module max_spanning_tree_kruskal_unit import mstk_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256,
   parameter int WEIGHT_BITS  = 16,
   localparam int DataBits    = ((2 * VERTEX_BITS + WEIGHT_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [VCOUNT_BITS-1:0] csr_wr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DataBits-1:0]    req_tdata,   // edge_from, edge_to, edge_weight
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DataBits-1:0]    rsp_tdata,   // tree_from, tree_to, tree_weight
   output logic                   rsp_tuser,   // tree_valid
   output logic                   rsp_tlast
);

   localparam int QW = 2 * VERTEX_BITS + WEIGHT_BITS + 1;

   logic [VCOUNT_BITS-1:0] vertex_count_ff;
   logic                   fq_valid, fq_ready, bq_valid, bq_ready;
   logic [QW-1:0]          fq_data, bq_data;
   logic [VERTEX_BITS-1:0] out_from, out_to;
   logic [WEIGHT_BITS-1:0] out_weight;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VCOUNT_RESET;
      end else if (csr_wr_en) begin
         vertex_count_ff <= csr_wr_data;
      end
   end

   mstk_front #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .in_from      (req_tdata[VERTEX_BITS-1:0]),
      .in_to        (req_tdata[2*VERTEX_BITS-1:VERTEX_BITS]),
      .in_weight    (req_tdata[2*VERTEX_BITS +: WEIGHT_BITS]),
      .req_tlast    (req_tlast),
      .vertex_count (vertex_count_ff),
      .q_valid      (fq_valid),
      .q_ready      (fq_ready),
      .q_data       (fq_data)
   );

   mstk_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (bq_valid),
      .pop_ready  (bq_ready),
      .pop_data   (bq_data)
   );

   mstk_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (bq_valid),
      .q_ready    (bq_ready),
      .q_data     (bq_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_from   (out_from),
      .out_to     (out_to),
      .out_weight (out_weight),
      .out_ok     (rsp_tuser),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = DataBits'({out_weight, out_to, out_from});

endmodule
